@@ rtl/core/record_file_checksum_validator_macros.svh @@
// Assertion macros for the record file checksum validator.
// Used by the checker module; expects clk and rst_n in the enclosing scope.
`ifndef RECORD_FILE_CHECKSUM_VALIDATOR_MACROS_SVH
`define RECORD_FILE_CHECKSUM_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCV_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RCV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rcv_pkg.sv @@
// Shared types and constants for the record file checksum validator.
// No dependencies; imported by the core, the top level and the checker.
package rcv_pkg;

  // File format constants
  localparam logic [31:0] MAGIC_WORD      = 32'h0100_00BD;
  localparam logic [30:0] LEN_LIMIT_RESET = 31'd16777216;
  localparam logic [3:0]  SHIFT_STEP      = 4'd3;

  // Field kind codes
  localparam logic [2:0] KIND_MAGIC    = 3'd0;
  localparam logic [2:0] KIND_COUNT    = 3'd1;
  localparam logic [2:0] KIND_NAME_LEN = 3'd2;
  localparam logic [2:0] KIND_VAL_LEN  = 3'd3;
  localparam logic [2:0] KIND_NAME     = 3'd4;
  localparam logic [2:0] KIND_VALUE    = 3'd5;
  localparam logic [2:0] KIND_CHECK    = 3'd6;
  localparam logic [2:0] KIND_IGNORED  = 3'd7;

  // Verdict codes
  localparam logic [2:0] VERDICT_PENDING   = 3'd0;
  localparam logic [2:0] VERDICT_OK        = 3'd1;
  localparam logic [2:0] VERDICT_BAD_MAGIC = 3'd2;
  localparam logic [2:0] VERDICT_NEG_COUNT = 3'd3;
  localparam logic [2:0] VERDICT_BAD_LEN   = 3'd4;
  localparam logic [2:0] VERDICT_TRUNC     = 3'd5;
  localparam logic [2:0] VERDICT_MISMATCH  = 3'd6;

  // Result tdata layout: data_byte, string_end, verdict, zero fill
  localparam int OUT_DATA_W  = 16;
  localparam int VERDICT_LSB = 9;
  localparam int VERDICT_W   = 3;
  localparam int IN_DATA_W   = 8;

  // Parser phase, one-hot
  typedef enum logic [7:0] {
    PH_MAGIC   = 8'b0000_0001,
    PH_COUNT   = 8'b0000_0010,
    PH_NAMELEN = 8'b0000_0100,
    PH_VALLEN  = 8'b0000_1000,
    PH_NAME    = 8'b0001_0000,
    PH_VALUE   = 8'b0010_0000,
    PH_CHECK   = 8'b0100_0000,
    PH_DONE    = 8'b1000_0000
  } phase_t;

  // One result transaction
  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] data_byte;
    logic       string_end;
    logic [2:0] verdict;
    logic       file_end;
  } rcv_result_t;

  // One input transaction
  typedef struct packed {
    logic       last_byte;
    logic [7:0] byte_value;
  } rcv_item_t;

endpackage

@@ rtl/core/rcv_pipe_reg.sv @@
// Valid/ready register stage; one payload register with a valid flag.
// Depends on nothing; used for the input and result stages.
module rcv_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  // Take a new transaction when empty or when the held one leaves
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

@@ rtl/core/rcv_core.sv @@
// Parser state and per-byte update: word assembly, length checks, checksum.
// Depends on rcv_pkg; the result is captured by the output stage.
module rcv_core
  import rcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  rcv_item_t   item,
  input  logic [30:0] max_len,
  output rcv_result_t result
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  wbi_r, wbi_nxt;
  logic [31:0] word_r, word_nxt;
  logic [30:0] recs_r, recs_nxt;
  logic [30:0] vlen_r, vlen_nxt;
  logic [30:0] left_r, left_nxt;
  logic        name_bad_r, name_bad_nxt;
  logic [31:0] csum_r, csum_nxt;
  logic [3:0]  shift_r, shift_nxt;
  logic [2:0]  verdict_r, verdict_nxt;

  logic [7:0]  b;
  logic [31:0] w;
  logic [31:0] b_ext;
  logic [30:0] recs_dec;
  logic [30:0] left_dec;
  logic [2:0]  kind;
  logic        send;
  logic        len_bad;

  assign b     = item.byte_value;
  assign b_ext = {24'd0, b};
  // Completed word when the top byte arrives
  assign w        = {b, word_r[23:0]};
  assign recs_dec = recs_r - 31'd1;
  assign left_dec = left_r - 31'd1;
  assign len_bad  = name_bad_r || (left_r > max_len) || w[31] || (w[30:0] > max_len);

  // Next state for one byte
  always_comb begin
    phase_nxt    = phase_r;
    wbi_nxt      = wbi_r;
    word_nxt     = word_r;
    recs_nxt     = recs_r;
    vlen_nxt     = vlen_r;
    left_nxt     = left_r;
    name_bad_nxt = name_bad_r;
    csum_nxt     = csum_r;
    shift_nxt    = shift_r;
    verdict_nxt  = verdict_r;
    kind         = KIND_IGNORED;
    send         = 1'b0;

    unique case (phase_r)
      PH_MAGIC, PH_COUNT, PH_NAMELEN, PH_VALLEN, PH_CHECK: begin
        unique case (phase_r)
          PH_MAGIC:   kind = KIND_MAGIC;
          PH_COUNT:   kind = KIND_COUNT;
          PH_NAMELEN: kind = KIND_NAME_LEN;
          PH_VALLEN:  kind = KIND_VAL_LEN;
          default:    kind = KIND_CHECK;
        endcase
        if (wbi_r == 2'd3) begin
          wbi_nxt  = 2'd0;
          word_nxt = 32'd0;
          unique case (phase_r)
            PH_MAGIC: begin
              if (w != MAGIC_WORD) begin
                verdict_nxt = VERDICT_BAD_MAGIC;
                phase_nxt   = PH_DONE;
              end else begin
                phase_nxt = PH_COUNT;
              end
            end
            PH_COUNT: begin
              if (w[31]) begin
                verdict_nxt = VERDICT_NEG_COUNT;
                phase_nxt   = PH_DONE;
              end else begin
                recs_nxt  = w[30:0];
                phase_nxt = (w[30:0] == 31'd0) ? PH_CHECK : PH_NAMELEN;
              end
            end
            PH_NAMELEN: begin
              // Name length is checked together with the value length
              left_nxt     = w[30:0];
              name_bad_nxt = w[31];
              phase_nxt    = PH_VALLEN;
            end
            PH_VALLEN: begin
              if (len_bad) begin
                verdict_nxt = VERDICT_BAD_LEN;
                phase_nxt   = PH_DONE;
              end else begin
                vlen_nxt  = w[30:0];
                csum_nxt  = csum_r + {1'b0, left_r} + {1'b0, w[30:0]};
                shift_nxt = 4'd0;
                if (left_r != 31'd0) begin
                  phase_nxt = PH_NAME;
                end else if (w[30:0] != 31'd0) begin
                  // empty name, go straight to the value
                  left_nxt  = w[30:0];
                  phase_nxt = PH_VALUE;
                end else begin
                  // empty record
                  recs_nxt  = recs_dec;
                  phase_nxt = (recs_dec == 31'd0) ? PH_CHECK : PH_NAMELEN;
                end
              end
            end
            default: begin
              verdict_nxt = (w == csum_r) ? VERDICT_OK : VERDICT_MISMATCH;
              phase_nxt   = PH_DONE;
            end
          endcase
        end else begin
          wbi_nxt = wbi_r + 2'd1;
          word_nxt[{wbi_r, 3'b000} +: 8] = b;
        end
      end
      PH_NAME, PH_VALUE: begin
        kind      = (phase_r == PH_NAME) ? KIND_NAME : KIND_VALUE;
        csum_nxt  = csum_r + b_ext + (b_ext << shift_r);
        shift_nxt = shift_r + SHIFT_STEP;
        left_nxt  = left_dec;
        if (left_dec == 31'd0) begin
          send      = 1'b1;
          shift_nxt = 4'd0;
          if (phase_r == PH_NAME && vlen_r != 31'd0) begin
            left_nxt  = vlen_r;
            phase_nxt = PH_VALUE;
          end else begin
            recs_nxt  = recs_dec;
            phase_nxt = (recs_dec == 31'd0) ? PH_CHECK : PH_NAMELEN;
          end
        end
      end
      default: begin
        // done: trailing bytes change nothing
      end
    endcase

    // A file that ends before a verdict is truncated
    if (item.last_byte && verdict_nxt == VERDICT_PENDING) begin
      verdict_nxt = VERDICT_TRUNC;
    end
  end

  assign result.field_kind = kind;
  assign result.data_byte  = b;
  assign result.string_end = send;
  assign result.verdict    = verdict_nxt;
  assign result.file_end   = item.last_byte;

  // State registers; end of file restarts the parser
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && item.last_byte)) begin
      phase_r    <= PH_MAGIC;
      wbi_r      <= 2'd0;
      word_r     <= 32'd0;
      recs_r     <= 31'd0;
      vlen_r     <= 31'd0;
      left_r     <= 31'd0;
      name_bad_r <= 1'b0;
      csum_r     <= MAGIC_WORD;
      shift_r    <= 4'd0;
      verdict_r  <= VERDICT_PENDING;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      wbi_r      <= wbi_nxt;
      word_r     <= word_nxt;
      recs_r     <= recs_nxt;
      vlen_r     <= vlen_nxt;
      left_r     <= left_nxt;
      name_bad_r <= name_bad_nxt;
      csum_r     <= csum_nxt;
      shift_r    <= shift_nxt;
      verdict_r  <= verdict_nxt;
    end
  end

endmodule

@@ rtl/core/record_file_checksum_validator.sv @@
// Record file checksum validator, top level.
// An accepted input transaction passes the input register, then the result register.
// Throughput: one byte per cycle; the parser update sits between the input
// register and the result register, and both stages hold under backpressure.
// Reset (rst_n low, synchronous) clears the parser and the pipeline and sets
// max_string_len to 1 << 24; a byte with tlast set returns the parser to start.
module record_file_checksum_validator
  import rcv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] byte_value
  input  logic                  in_tlast,   // last_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] data_byte, [8] string_end,
                                            // [11:9] verdict, [15:12] zero
  output logic [2:0]            out_tuser,  // [2:0] field_kind
  output logic                  out_tlast,  // file_end
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [30:0]           cfg_wr_data // max_string_len
);

  logic        s1_valid;
  logic        s2_ready;
  rcv_item_t   in_item;
  rcv_item_t   s1_item;
  rcv_result_t core_res;
  rcv_result_t out_res;
  logic [30:0] max_len_r;

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  assign in_item.byte_value = in_tdata;
  assign in_item.last_byte  = in_tlast;

  // Input register
  rcv_pipe_reg #(.W($bits(rcv_item_t))) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_item),
    .out_valid(s1_valid),
    .out_ready(s2_ready),
    .out_data (s1_item)
  );

  // Parser, stepped when the byte moves into the result register
  rcv_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(s1_valid && s2_ready),
    .item   (s1_item),
    .max_len(max_len_r),
    .result (core_res)
  );

  // Result register
  rcv_pipe_reg #(.W($bits(rcv_result_t))) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid),
    .in_ready (s2_ready),
    .in_data  (core_res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_res)
  );

  assign out_tdata = {4'd0, out_res.verdict, out_res.string_end, out_res.data_byte};
  assign out_tuser = out_res.field_kind;
  assign out_tlast = out_res.file_end;

endmodule

@@ rtl/core/rcv_checker.sv @@
// Port-level checker for the record file checksum validator, with its bind.
// Depends on rcv_pkg and record_file_checksum_validator_macros.svh.
`include "record_file_checksum_validator_macros.svh"

module rcv_checker
  import rcv_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]            out_tuser,
  input logic                  out_tlast
);

  // A stalled result transaction holds
  `RCV_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // The closing byte of a file always carries a final verdict
  `RCV_ASSERT_SAME(a_end_verdict, out_tvalid && out_tlast, out_tdata[VERDICT_LSB +: VERDICT_W] != VERDICT_PENDING, "file closed with pending verdict")

  // String end only on name or value bytes
  `RCV_ASSERT_SAME(a_send_kind, out_tvalid && out_tdata[8], out_tuser == KIND_NAME || out_tuser == KIND_VALUE, "string end on a non-string byte")

  // Ignored bytes only follow a settled verdict
  `RCV_ASSERT_SAME(a_ignored_verdict, out_tvalid && out_tuser == KIND_IGNORED, out_tdata[VERDICT_LSB +: VERDICT_W] != VERDICT_PENDING, "ignored byte while verdict pending")

endmodule

bind record_file_checksum_validator rcv_checker u_rcv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

@@ test/record_file_checksum_validator_tb.sv @@
// Testbench for record_file_checksum_validator: random and directed record files
// with a byte-level predictor of the parser and a scoreboard on the result stream.
// Depends on rcv_pkg and the record_file_checksum_validator RTL only.
module record_file_checksum_validator_tb;
  import rcv_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_BYTES  = 210;
  localparam int HOLD_AT      = 350;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 10;

  // Kinds of damage applied to a generated file
  typedef enum int {
    FLAW_NONE, FLAW_TRAIL, FLAW_MAGIC, FLAW_NEG_COUNT,
    FLAW_BAD_LEN, FLAW_CSUM, FLAW_TRUNC, FLAW_NOISE
  } flaw_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [30:0]           cfg_wr_data = '0;

  record_file_checksum_validator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage
  rcv_item_t   pending_bytes[$];
  rcv_result_t expected_results[$];
  logic [7:0]  file_q[$];
  int          n_queued = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          hold_left = 0;
  bit          hold_used = 1'b0;

  // Parser model state
  logic [30:0] max_len;
  logic [2:0]  ph;
  logic [1:0]  word_idx;
  logic [31:0] word_acc;
  logic [30:0] recs_left;
  logic [30:0] value_len_held;
  logic [31:0] str_left;
  logic [31:0] csum;
  logic [3:0]  shift_amt;
  logic [2:0]  verdict_now;

  function automatic void clear_parser();
    ph             = KIND_MAGIC;
    word_idx       = '0;
    word_acc       = '0;
    recs_left      = '0;
    value_len_held = '0;
    str_left       = '0;
    csum           = MAGIC_WORD;
    shift_amt      = '0;
    verdict_now    = VERDICT_PENDING;
  endfunction

  function automatic void fail_file(input logic [2:0] code);
    verdict_now = code;
    ph          = KIND_IGNORED;
  endfunction

  function automatic void record_done();
    recs_left = recs_left - 31'd1;
    ph        = (recs_left == '0) ? KIND_CHECK : KIND_NAME_LEN;
  endfunction

  // Name finished (or empty): move to the value or close the record
  function automatic void name_done();
    shift_amt = '0;
    if (value_len_held != '0) begin
      str_left = {1'b0, value_len_held};
      ph       = KIND_VALUE;
    end else begin
      record_done();
    end
  endfunction

  // Advance the model by one byte and return the result it should produce
  function automatic rcv_result_t parse_byte(input logic [7:0] b, input logic last);
    rcv_result_t r;
    logic [31:0] w;
    logic        send;
    r.field_kind = KIND_IGNORED;
    send         = 1'b0;
    case (ph)
      KIND_MAGIC, KIND_COUNT, KIND_NAME_LEN, KIND_VAL_LEN, KIND_CHECK: begin
        r.field_kind = ph;
        word_acc = word_acc | (32'(b) << (8 * word_idx));
        if (word_idx == 2'd3) begin
          w        = word_acc;
          word_idx = '0;
          word_acc = '0;
          case (ph)
            KIND_MAGIC: begin
              if (w != MAGIC_WORD) fail_file(VERDICT_BAD_MAGIC);
              else ph = KIND_COUNT;
            end
            KIND_COUNT: begin
              if (w[31]) begin
                fail_file(VERDICT_NEG_COUNT);
              end else begin
                recs_left = w[30:0];
                ph = (recs_left == '0) ? KIND_CHECK : KIND_NAME_LEN;
              end
            end
            KIND_NAME_LEN: begin
              // a negative name length is flagged once the value length is in
              str_left = w[31] ? 32'(max_len) + 32'd1 : {1'b0, w[30:0]};
              ph       = KIND_VAL_LEN;
            end
            KIND_VAL_LEN: begin
              if (str_left > 32'(max_len) || w[31] || w[30:0] > max_len) begin
                fail_file(VERDICT_BAD_LEN);
              end else begin
                value_len_held = w[30:0];
                csum      = csum + str_left + 32'(value_len_held);
                shift_amt = '0;
                if (str_left != '0) ph = KIND_NAME;
                else name_done();
              end
            end
            default: fail_file((w == csum) ? VERDICT_OK : VERDICT_MISMATCH);
          endcase
        end else begin
          word_idx = word_idx + 2'd1;
        end
      end
      KIND_NAME, KIND_VALUE: begin
        r.field_kind = ph;
        csum      = csum + 32'(b) + (32'(b) << shift_amt);
        shift_amt = shift_amt + SHIFT_STEP;
        str_left  = {1'b0, str_left[30:0] - 31'd1};
        if (str_left == '0) begin
          send = 1'b1;
          if (ph == KIND_NAME) begin
            name_done();
          end else begin
            shift_amt = '0;
            record_done();
          end
        end
      end
      default: ;
    endcase
    if (last && verdict_now == VERDICT_PENDING) verdict_now = VERDICT_TRUNC;
    r.data_byte  = b;
    r.string_end = send;
    r.verdict    = verdict_now;
    r.file_end   = last;
    if (last) clear_parser();
    return r;
  endfunction

  // Source driver: takes bytes from the pending queue, with random gaps
  always @(posedge clk) begin
    rcv_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(parse_byte(in_tdata, in_tlast));
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nxt = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.byte_value;
          in_tlast  <= nxt.last_byte;
          if (!quiet && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 19);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the pipeline fills and backs up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && bytes_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Result monitor: compares each transaction with the oldest expectation
  always @(posedge clk) begin
    rcv_result_t got;
    rcv_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.field_kind = out_tuser;
        got.data_byte  = out_tdata[7:0];
        got.string_end = out_tdata[8];
        got.verdict    = out_tdata[VERDICT_LSB +: VERDICT_W];
        got.file_end   = out_tlast;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result transaction: kind %0d byte %02h", got.field_kind,
                     got.data_byte);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || out_tdata[OUT_DATA_W-1:VERDICT_LSB+VERDICT_W] !== '0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"mismatch: exp kind %0d byte %02h end %0b verdict %0d last %0b, ",
                        "got kind %0d byte %02h end %0b verdict %0d last %0b fill %h"},
                       want.field_kind, want.data_byte, want.string_end, want.verdict,
                       want.file_end, got.field_kind, got.data_byte, got.string_end,
                       got.verdict, got.file_end,
                       out_tdata[OUT_DATA_W-1:VERDICT_LSB+VERDICT_W]);
          end
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(0, 18);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("record_file_checksum_validator_tb: errors");
      $finish;
    end
  end

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[8*i +: 8]);
  endtask

  // Random bytes after an error word, all of them ignored by the parser
  task automatic add_junk();
    repeat ($urandom_range(0, 5)) file_q.push_back(8'($urandom));
  endtask

  task automatic put_string(input logic [31:0] len, inout logic [31:0] sum);
    logic [3:0] sh;
    logic [7:0] b;
    sh = '0;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      file_q.push_back(b);
      sum = sum + 32'(b) + (32'(b) << sh);
      sh  = sh + SHIFT_STEP;
    end
  endtask

  // Move the assembled file to the driver, tlast on its final byte
  task automatic send_file();
    rcv_item_t it;
    foreach (file_q[i]) begin
      it.byte_value = file_q[i];
      it.last_byte  = (i == file_q.size() - 1);
      pending_bytes.push_back(it);
    end
    n_queued += file_q.size();
    file_q.delete();
  endtask

  function automatic logic [31:0] pick_len();
    int unsigned cap;
    cap = ($urandom_range(0, 7) == 0) ? 40 : 8;
    if (max_len < cap) cap = 32'(max_len);
    return $urandom_range(0, cap);
  endfunction

  function automatic logic [31:0] over_len();
    if (max_len == 31'h7FFF_FFFF) return 32'h8000_0000 | $urandom;
    return 32'(max_len) + 32'd1 + $urandom_range(0, 1000);
  endfunction

  // Build one file, mostly well formed, sometimes damaged
  task automatic build_file();
    flaw_t       flaw;
    int unsigned nrec;
    int unsigned bad_rec;
    int          keep;
    logic [31:0] sum;
    logic [31:0] nl;
    logic [31:0] vl;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: flaw = FLAW_NONE;
      9, 10:  flaw = FLAW_TRAIL;
      11:     flaw = FLAW_MAGIC;
      12:     flaw = FLAW_NEG_COUNT;
      13, 14: flaw = FLAW_BAD_LEN;
      15, 16: flaw = FLAW_CSUM;
      17, 18: flaw = FLAW_TRUNC;
      default: flaw = FLAW_NOISE;
    endcase
    file_q.delete();
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 10)) file_q.push_back(8'($urandom));
      send_file();
      return;
    end
    nrec = $urandom_range(0, 4);
    if (flaw == FLAW_BAD_LEN && nrec == 0) nrec = 1;
    bad_rec = $urandom_range(0, (nrec > 0) ? nrec - 1 : 0);
    sum = MAGIC_WORD;
    if (flaw == FLAW_MAGIC) begin
      put_word(MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31)));
      add_junk();
      send_file();
      return;
    end
    put_word(MAGIC_WORD);
    if (flaw == FLAW_NEG_COUNT) begin
      put_word({1'b1, 31'($urandom)});
      add_junk();
      send_file();
      return;
    end
    // a huge count only makes sense when the file is cut short anyway
    if (flaw == FLAW_TRUNC && $urandom_range(0, 2) == 0)
      put_word({1'b0, 31'($urandom)} | 32'h100);
    else
      put_word(nrec);
    for (int r = 0; r < nrec; r++) begin
      nl = pick_len();
      vl = pick_len();
      if (flaw == FLAW_BAD_LEN && r == bad_rec) begin
        case ($urandom_range(0, 3))
          0: nl = 32'h8000_0000 | $urandom;
          1: vl = 32'h8000_0000 | $urandom;
          2: nl = over_len();
          default: vl = over_len();
        endcase
        put_word(nl);
        put_word(vl);
        add_junk();
        send_file();
        return;
      end
      put_word(nl);
      put_word(vl);
      sum = sum + nl + vl;
      put_string(nl, sum);
      put_string(vl, sum);
    end
    put_word((flaw == FLAW_CSUM) ? sum ^ (32'd1 << $urandom_range(0, 31)) : sum);
    if (flaw == FLAW_TRAIL) repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
    if (flaw == FLAW_TRUNC) begin
      keep = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    send_file();
  endtask

  // Wait until every queued byte has been taken and every result checked
  task automatic wait_drained();
    do @(posedge clk);
    while (bytes_taken != n_queued || expected_results.size() != 0);
  endtask

  task automatic write_limit(input logic [30:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    max_len = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [30:0] limits[6];
    int          phase_start;
    limits = '{31'd0, 31'h7FFF_FFFF, 31'd7, 31'd3, LEN_LIMIT_RESET,
               31'($urandom_range(1, 40))};
    max_len = LEN_LIMIT_RESET;
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed files at the reset limit
    put_word(MAGIC_WORD);
    put_word(32'd0);
    put_word(MAGIC_WORD);
    send_file();                          // zero records, checksum is the magic value
    file_q.push_back(8'h00);
    send_file();                          // file ends on its first byte
    put_word(32'hFFFF_FFFF);
    send_file();                          // bad magic on the closing byte
    put_word(MAGIC_WORD);
    put_word(32'h8000_0000);
    send_file();                          // negative record count
    wait_drained();

    // Random files under a series of length limits; the last series runs without gaps
    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (p == $size(limits) - 1) quiet = 1'b1;
      phase_start = n_queued;
      while (n_queued - phase_start < PHASE_BYTES) build_file();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("record_file_checksum_validator_tb: clean");
    end else begin
      $display("record_file_checksum_validator_tb: errors");
    end
    $finish;
  end

endmodule
